@@ design/shash_pkg.sv @@
// Package for the SHA-256 stream hasher: round constants, initial hash words
// and the fixed widths of the datapath. No dependencies.
`default_nettype none

package shash_pkg;

	localparam int WORD_W   = 32;
	localparam int CHAIN_N  = 8;
	localparam int SCHED_N  = 16;
	localparam int ROUNDS   = 64;
	localparam int LEN_W    = 64;
	localparam int BYTES_W  = 61;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WORD_W-1:0] INIT_HASH [CHAIN_N] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

endpackage

`default_nettype wire

@@ design/shash_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read is not enabled.
`default_nettype none

module shash_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/sha256_stream_hasher_top.sv @@
// SHA-256 stream hasher top level: byte collection, padding, round datapath
// and digest output. Depends on shash_pkg and shash_ram.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid, in_ready, data_byte, byte_present,    | sink
//           | end_of_message                                  |
//   out     | out_valid, out_ready, digest_word, word_index,  | source
//           | last_word                                       |
//
// A byte is taken while in_ready is high. The 64th byte of a block starts a
// compression (chain RAM load, 64 rounds, read-add-write of the chain RAM).
// End of message: the padding and length bytes are shifted in, with a step
// to latch the length, then one or two compressions, then the chain RAM is
// read out word by word, stalling on the output, and re-initialized.
// After reset a pass writes the initial hash words; in_ready is low.
// The last digest word can wait in the output register while bytes are accepted.
`default_nettype none

module sha256_stream_hasher_top
	import shash_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_PAD80 = 4'd2;
	localparam logic [3:0] ST_PADZ  = 4'd3;
	localparam logic [3:0] ST_LEN   = 4'd4;
	localparam logic [3:0] ST_LOAD  = 4'd5;
	localparam logic [3:0] ST_RND   = 4'd6;
	localparam logic [3:0] ST_UPD   = 4'd7;
	localparam logic [3:0] ST_ORD   = 4'd8;
	localparam logic [3:0] ST_OLD   = 4'd9;

	localparam int AW = $clog2(CHAIN_N);
	localparam logic [5:0] CNT_LAST_LOAD = 6'(CHAIN_N);
	localparam logic [5:0] CNT_LAST_RND  = 6'(ROUNDS - 1);
	localparam logic [5:0] POS_LEN       = 6'd56;
	localparam logic [5:0] POS_LAST      = 6'd63;

	logic [3:0]         state_q, ret_q;
	logic [5:0]         cnt_q;
	logic [5:0]         pos_q;
	logic [BYTES_W-1:0] total_q;
	logic [LEN_W-1:0]   len_q;
	logic [WORD_W-1:0]  sched_q [SCHED_N];
	logic [WORD_W-1:0]  v_q [CHAIN_N];
	logic               out_valid_q;
	logic [31:0]        digest_q;
	logic [2:0]         index_q;
	logic               last_q;

	// chain RAM ports
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	shash_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CHAIN_N)
	) u_chain_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic in_fire, out_slot_free;
	assign in_ready      = (state_q == ST_IDLE);
	assign in_fire       = in_valid && in_ready;
	assign out_slot_free = !out_valid_q || out_ready;

	// select the byte that enters the block line this cycle
	logic       shift_en;
	logic [7:0] shift_byte;
	always_comb begin
		shift_en   = 1'b0;
		shift_byte = 8'h00;
		case (state_q)
			ST_IDLE: begin
				shift_en   = in_fire && byte_present;
				shift_byte = data_byte;
			end
			ST_PAD80: begin
				shift_en   = 1'b1;
				shift_byte = PAD_BYTE;
			end
			ST_PADZ: begin
				shift_en   = (pos_q != POS_LEN);
				shift_byte = 8'h00;
			end
			ST_LEN: begin
				shift_en   = 1'b1;
				shift_byte = len_q[LEN_W-1 -: 8];
			end
			default: begin
				shift_en   = 1'b0;
				shift_byte = 8'h00;
			end
		endcase
	end

	// round function
	logic [WORD_W-1:0] s0_big, s1_big, ch, maj, t1, t2, w_new, ws0, ws1;
	always_comb begin
		s1_big = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		s0_big = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + s1_big + ch + ROUND_K[cnt_q] + sched_q[0];
		t2     = s0_big + maj;
		ws1    = rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10);
		ws0    = rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3);
		w_new  = ws1 + sched_q[9] + ws0 + sched_q[0];
	end

	// chain RAM access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = INIT_HASH[cnt_q[AW-1:0]];
		ram_re    = 1'b0;
		ram_raddr = cnt_q[AW-1:0];
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
			end
			ST_LOAD: begin
				ram_re = (cnt_q < CNT_LAST_LOAD);
			end
			ST_UPD: begin
				ram_re    = (cnt_q < CNT_LAST_LOAD);
				ram_we    = (cnt_q != 6'd0);
				ram_waddr = AW'(cnt_q - 6'd1);
				ram_wdata = ram_rdata + v_q[0];
			end
			ST_ORD: begin
				ram_re = 1'b1;
			end
			ST_OLD: begin
				ram_we = out_slot_free;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ret_q   <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			total_q <= '0;
		end else begin
			if (shift_en) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				ST_INIT: begin
					if (cnt_q[AW-1:0] == AW'(CHAIN_N - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (byte_present) begin
							total_q <= total_q + BYTES_W'(1);
						end
						if (byte_present && pos_q == POS_LAST) begin
							cnt_q   <= '0;
							ret_q   <= end_of_message ? ST_PAD80 : ST_IDLE;
							state_q <= ST_LOAD;
						end else if (end_of_message) begin
							state_q <= ST_PAD80;
						end
					end
				end
				ST_PAD80: begin
					if (pos_q == POS_LAST) begin
						cnt_q   <= '0;
						ret_q   <= ST_PADZ;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_PADZ;
					end
				end
				ST_PADZ: begin
					if (pos_q == POS_LEN) begin
						state_q <= ST_LEN;
					end else if (pos_q == POS_LAST) begin
						cnt_q   <= '0;
						ret_q   <= ST_PADZ;
						state_q <= ST_LOAD;
					end
				end
				ST_LEN: begin
					if (pos_q == POS_LAST) begin
						total_q <= '0;
						cnt_q   <= '0;
						ret_q   <= ST_ORD;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (cnt_q == CNT_LAST_LOAD) begin
						cnt_q   <= '0;
						state_q <= ST_RND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_RND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == CNT_LAST_RND) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (cnt_q == CNT_LAST_LOAD) begin
						cnt_q   <= '0;
						state_q <= ret_q;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ORD: begin
					state_q <= ST_OLD;
				end
				ST_OLD: begin
					if (out_slot_free) begin
						if (cnt_q[AW-1:0] == AW'(CHAIN_N - 1)) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + 6'd1;
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block line and message schedule share one shift line of words
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int k = 0; k < SCHED_N - 1; k++) begin
				sched_q[k] <= {sched_q[k][WORD_W-9:0], sched_q[k+1][WORD_W-1 -: 8]};
			end
			sched_q[SCHED_N-1] <= {sched_q[SCHED_N-1][WORD_W-9:0], shift_byte};
		end else if (state_q == ST_RND) begin
			for (int k = 0; k < SCHED_N - 1; k++) begin
				sched_q[k] <= sched_q[k+1];
			end
			sched_q[SCHED_N-1] <= w_new;
		end
	end

	// latch the bit length, then shift it out most significant byte first
	always_ff @(posedge clk) begin
		if (state_q == ST_PADZ && pos_q == POS_LEN) begin
			len_q <= {total_q, 3'b000};
		end else if (state_q == ST_LEN) begin
			len_q <= {len_q[LEN_W-9:0], 8'h00};
		end
	end

	// working variables: load from chain RAM, run rounds, rotate for update
	always_ff @(posedge clk) begin
		if ((state_q == ST_LOAD || state_q == ST_UPD) && cnt_q != 6'd0) begin
			for (int k = 0; k < CHAIN_N - 1; k++) begin
				v_q[k] <= v_q[k+1];
			end
			v_q[CHAIN_N-1] <= (state_q == ST_LOAD) ? ram_rdata : v_q[0];
		end else if (state_q == ST_RND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// output register: hold a digest word until its transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OLD && out_slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OLD && out_slot_free) begin
			digest_q <= ram_rdata;
			index_q  <= cnt_q[2:0];
			last_q   <= (cnt_q[AW-1:0] == AW'(CHAIN_N - 1));
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = index_q;
	assign last_word   = last_q;

endmodule

`default_nettype wire

@@ dv/tb_sha256_stream_hasher_top.sv @@
`timescale 1ns / 1ps
// Testbench for sha256_stream_hasher_top: byte stream in, digest words out.
// Depends on shash_pkg for the round constants and initial hash words.

module tb_sha256_stream_hasher_top
	import shash_pkg::*;
();

	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;
	localparam int DIRECTED_N = 17;
	localparam int RANDOM_ITEMS = 390;
	localparam int EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	typedef struct {
		logic [7:0]   byte_val;
		bit           present;
		bit           eom;
		bit           has_known;
		logic [255:0] known;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// Predictor state
	logic [7:0]  msg_block [64];
	logic [5:0]  block_fill = '0;
	logic [63:0] msg_bits = '0;
	logic [31:0] hash_state [8] = INIT_HASH;

	digest_word_t digest_due [$];
	int mismatches = 0;
	int burst_left = 0;

	// Directed stimulus: known digests only where they are textbook values
	stim_row_t directed_rows [DIRECTED_N] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{8'h62, 1'b1, 1'b0, 1'b0, '0},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		'{8'ha5, 1'b0, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'hff, 1'b1, 1'b1, 1'b0, '0},
		'{8'h00, 1'b1, 1'b1, 1'b0, '0},
		'{8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h61, 1'b1, 1'b0, 1'b0, '0},
		'{8'h62, 1'b1, 1'b0, 1'b0, '0},
		'{8'h63, 1'b1, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b1, 1'b1, ABC_DIGEST},
		'{8'hff, 1'b1, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b0, 1'b0, '0},
		'{8'h01, 1'b1, 1'b1, 1'b0, '0}
	};

	sha256_stream_hasher_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run the 64 rounds over msg_block and fold the result into hash_state
	task automatic compress_msg_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wr, s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		v = hash_state;
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				s1 = ror32(w[(r-2) & 15], 17) ^ ror32(w[(r-2) & 15], 19) ^ (w[(r-2) & 15] >> 10);
				s0 = ror32(w[(r-15) & 15], 7) ^ ror32(w[(r-15) & 15], 18) ^ (w[(r-15) & 15] >> 3);
				wr = s1 + w[(r-7) & 15] + s0 + w[r & 15];
				w[r & 15] = wr;
			end
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	// Advance the hash state by one accepted transaction; queue the digest on end of message
	task automatic hash_step(input logic [7:0] b, input bit present, input bit eom,
			input bit has_known, input logic [255:0] known);
		int pos;
		digest_word_t dw;
		if (present) begin
			msg_block[block_fill] = b;
			block_fill = block_fill + 6'd1;
			if (block_fill == 6'd0) begin
				compress_msg_block();
				msg_bits = msg_bits + 64'd512;
			end
		end
		if (!eom)
			return;
		// Pad: marker byte, zeros, extra block when the length no longer fits
		pos = block_fill;
		msg_block[pos] = PAD_BYTE;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			compress_msg_block();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		msg_bits = msg_bits + 64'(block_fill) * 64'd8;
		for (int j = 0; j < 8; j++)
			msg_block[63 - j] = msg_bits[8*j +: 8];
		compress_msg_block();
		for (int i = 0; i < 8; i++) begin
			dw.word = has_known ? known[255 - 32*i -: 32] : hash_state[i];
			dw.idx = 3'(i);
			dw.last = (i == 7);
			digest_due.push_back(dw);
		end
		// Restart for the next message
		block_fill = '0;
		msg_bits = '0;
		hash_state = INIT_HASH;
	endtask

	// Offer one transaction in sender bursts, hold it until accepted, then predict
	task automatic push_message_item(input logic [7:0] b, input bit present, input bit eom,
			input bit has_known = 1'b0, input logic [255:0] known = '0);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= present;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		hash_step(b, present, eom, has_known, known);
	endtask

	// Reset once at start
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: cycle through four stall patterns in turn
	initial begin
		int rx_cycle;
		rx_mode_t rx_mode;
		rx_cycle = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			rx_mode = rx_mode_t'((rx_cycle / 300) % 4);
			case (rx_mode)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_COIN: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				RX_SPARSE: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					out_ready <= ((rx_cycle % 5) < 2);
				end
			endcase
		end
	end

	// Compare each digest transaction with the oldest expectation
	always @(posedge clk) begin
		digest_word_t exp_dw;
		if (arst_n && out_valid && out_ready) begin
			if (digest_due.size() == 0) begin
				$display("%0t: unexpected digest word: word %h index %0d last %0b",
					$time, digest_word, word_index, last_word);
				mismatches++;
			end else begin
				exp_dw = digest_due.pop_front();
				if (digest_word !== exp_dw.word) begin
					$display("%0t: digest_word expected %h actual %h",
						$time, exp_dw.word, digest_word);
					mismatches++;
				end
				if (word_index !== exp_dw.idx) begin
					$display("%0t: word_index expected %0d actual %0d",
						$time, exp_dw.idx, word_index);
					mismatches++;
				end
				if (last_word !== exp_dw.last) begin
					$display("%0t: last_word expected %0b actual %0b",
						$time, exp_dw.last, last_word);
					mismatches++;
				end
			end
		end
	end

	// Stimulus: directed table, then random messages with noise items
	initial begin
		int items_sent;
		int kind;
		int msg_len;
		bit tail_on_end;
		items_sent = 0;
		wait (arst_n === 1'b1);

		for (int k = 0; k < DIRECTED_N; k++)
			push_message_item(directed_rows[k].byte_val, directed_rows[k].present,
				directed_rows[k].eom, directed_rows[k].has_known, directed_rows[k].known);

		while (items_sent < RANDOM_ITEMS) begin
			// Pick a length: mostly short, some around the padding boundaries
			kind = $urandom_range(0, 9);
			if (kind < 6)
				msg_len = $urandom_range(0, 12);
			else if (kind < 8)
				msg_len = EDGE_LENGTHS[$urandom_range(0, 9)];
			else
				msg_len = $urandom_range(13, 70);
			tail_on_end = (msg_len > 0) && $urandom_range(0, 1);
			for (int i = 0; i < msg_len - tail_on_end; i++) begin
				if ($urandom_range(0, 7) == 0)
					push_message_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				push_message_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				items_sent++;
			end
			push_message_item(8'($urandom_range(0, 255)), tail_on_end, 1'b1);
			items_sent++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("sha256_stream_hasher_top test passed");
		else
			$display("sha256_stream_hasher_top test failed");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#20_000_000;
		$display("sha256_stream_hasher_top test failed");
		$finish;
	end

endmodule
